>>> hdl/mqpg_pkg.sv
// Shared constants and types for the mouse quadrature pulse generator.
// No dependencies.
package mqpg_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int DELTA_BITS_DEF  = 8;
  localparam int SLOT_W          = 16;
  localparam int TIME_W          = 64;
  localparam logic [SLOT_W-1:0] SLOT_RESET = 16'd10000;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic upd;
    logic tick;
  } axis_ctl_t;

endpackage

>>> hdl/mouse_quadrature_pulse_generator.sv
// Mouse quadrature pulse generator: front classifier, two-entry queue, per-axis back end.
// A tick goes straight through the front into the queue and enters the back when the result slot frees.
// An update holds the input stalled through the bit-serial slot divide, the multiply and the push.
// Results are registered.
// Synchronous active-low reset: queues empty, lines low, button line high, slot 10000.
module mouse_quadrature_pulse_generator import mqpg_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DELTA_BITS  = DELTA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [SLOT_W-1:0]     cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic                  in_button,
  input  logic [DELTA_BITS-1:0] in_delta_x,
  input  logic [DELTA_BITS-1:0] in_delta_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_x_phase_a,
  output logic                  out_x_phase_b,
  output logic                  out_y_phase_a,
  output logic                  out_y_phase_b,
  output logic                  out_button_line,
  output logic                  out_dropped
);

  localparam int SW = DELTA_BITS - 1;
  localparam int PW = SLOT_W + SW;
  localparam int EW = 2 + 2 * (SLOT_W + PW + SW + 1);
  localparam int UW = $clog2(QUEUE_DEPTH + 1);

  logic [SLOT_W-1:0] slot_r;
  logic [TIME_W-1:0] time_r, time_inc;
  logic              btn_r, dropped_r, ovalid_r;
  logic              f_push, f_full, f_empty, pop;
  logic [EW-1:0]     f_din, f_dout;

  logic              e_tick, e_btn, e_dx, e_dy;
  logic [SLOT_W-1:0] e_px, e_py;
  logic [PW-1:0]     e_mx, e_my;
  logic [SW-1:0]     e_sx, e_sy;
  axis_ctl_t         ctl;
  logic              drop_x, drop_y;
  logic [UW-1:0]     used_x, used_y;

  always_ff @(posedge clk) begin
    if (!rst_n)         slot_r <= SLOT_RESET;
    else if (cfg_wr_en) slot_r <= cfg_wr_data;
  end

  mqpg_front #(.DELTA_BITS(DELTA_BITS), .EW(EW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_button(in_button), .in_delta_x(in_delta_x),
    .in_delta_y(in_delta_y), .slot(slot_r), .fifo_full(f_full),
    .fifo_push(f_push), .fifo_din(f_din)
  );

  mqpg_fifo #(.W(EW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_push), .din(f_din), .pop(pop),
    .dout(f_dout), .full(f_full), .empty(f_empty)
  );

  assign {e_tick, e_btn, e_px, e_mx, e_sx, e_dx, e_py, e_my, e_sy, e_dy} = f_dout;

  // Take the next item only when the result register is free or draining.
  assign pop      = !f_empty && (!ovalid_r || !out_stall);
  assign ctl.upd  = pop && (e_tick == OP_UPDATE);
  assign ctl.tick = pop && (e_tick == OP_TICK);
  assign time_inc = time_r + 1'b1;

  mqpg_axis #(.QD(QUEUE_DEPTH), .SW(SW), .IS_Y(1'b0)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .now(time_r), .now_inc(time_inc),
    .per(e_px), .prod(e_mx), .steps(e_sx), .dir(e_dx),
    .level(out_x_phase_a), .quad(out_x_phase_b), .drop(drop_x), .used(used_x)
  );

  mqpg_axis #(.QD(QUEUE_DEPTH), .SW(SW), .IS_Y(1'b1)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .now(time_r), .now_inc(time_inc),
    .per(e_py), .prod(e_my), .steps(e_sy), .dir(e_dy),
    .level(out_y_phase_a), .quad(out_y_phase_b), .drop(drop_y), .used(used_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      btn_r     <= 1'b1;
      dropped_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (ctl.tick) time_r <= time_inc;
      if (ctl.upd)  btn_r  <= ~e_btn;
      if (pop)      dropped_r <= ctl.upd && (drop_x || drop_y);
      if (pop)            ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_button_line = btn_r;
  assign out_dropped     = dropped_r;

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    time_r == $past(time_r) || time_r == $past(time_r) + 1'b1)
    else $error("time counter jumped");

  a_fifo_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_push && f_full))
    else $error("push into full queue");

  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_x <= UW'(QUEUE_DEPTH) && used_y <= UW'(QUEUE_DEPTH))
    else $error("batch queue overfilled");

  a_drop_upd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tick |=> !dropped_r)
    else $error("drop flagged on a tick");

endmodule

>>> hdl/mqpg_div.sv
// Restoring divider, one quotient bit per cycle, for the slot period.
// Depends on mqpg_pkg.
module mqpg_div import mqpg_pkg::*; #(
  parameter int DW = DELTA_BITS_DEF - 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SLOT_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic              busy,
  output logic [SLOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(SLOT_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [DW:0]       rem_r;
  logic [SLOT_W-1:0] quot_r;
  logic [DW-1:0]     dsr_r;
  logic [DW:0]       sh;
  logic              ge;

  assign sh = {rem_r[DW-1:0], quot_r[SLOT_W-1]};
  assign ge = sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(SLOT_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
      dsr_r  <= divisor;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? (sh - {1'b0, dsr_r}) : sh;
      quot_r <= {quot_r[SLOT_W-2:0], ge};
    end
  end

  assign busy = cnt_r != '0;
  assign quot = quot_r;

endmodule

>>> hdl/mqpg_fifo.sv
// Two-entry queue between the front classifier and the back executor.
// Depends on nothing but its width parameter.
module mqpg_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

>>> hdl/mqpg_front.sv
// Front end: accepts items, scales deltas, divides the slot and forms the batch product.
// Depends on mqpg_pkg, mqpg_div.
module mqpg_front import mqpg_pkg::*; #(
  parameter int DELTA_BITS = DELTA_BITS_DEF,
  parameter int EW = 2 + 2 * (2 * SLOT_W + 2 * (DELTA_BITS - 1) + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic                  in_button,
  input  logic [DELTA_BITS-1:0] in_delta_x,
  input  logic [DELTA_BITS-1:0] in_delta_y,
  input  logic [SLOT_W-1:0]     slot,
  input  logic                  fifo_full,
  output logic                  fifo_push,
  output logic [EW-1:0]         fifo_din
);

  localparam int SW = DELTA_BITS - 1;
  localparam int PW = SLOT_W + SW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              btn_r;
  logic [SW-1:0]     stx_r, sty_r;
  logic              dirx_r, diry_r;
  logic [SLOT_W-1:0] perx_r, pery_r;
  logic [PW-1:0]     prodx_r, prody_r;
  logic              accept, start;
  logic              bsy_x, bsy_y;
  logic [SLOT_W-1:0] qx, qy;
  logic [SW-1:0]     stx_in, sty_in;

  function automatic logic [SW-1:0] scale(input logic [DELTA_BITS-1:0] d);
    logic [DELTA_BITS-1:0] mag;
    mag = d[DELTA_BITS-1] ? (~d + 1'b1) : d;
    return (mag > DELTA_BITS'(1)) ? mag[DELTA_BITS-1:1] : mag[SW-1:0];
  endfunction

  assign stx_in   = scale(in_delta_x);
  assign sty_in   = scale(in_delta_y);
  assign in_stall = (state_r != S_IDLE) || fifo_full;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_opcode == OP_UPDATE);

  mqpg_div #(.DW(SW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(start), .dividend(slot), .divisor(stx_in),
    .busy(bsy_x), .quot(qx)
  );
  mqpg_div #(.DW(SW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(start), .dividend(slot), .divisor(sty_in),
    .busy(bsy_y), .quot(qy)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DIV;
      S_DIV:  if (!bsy_x && !bsy_y) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_PUSH;
      S_PUSH: if (!fifo_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      btn_r  <= in_button;
      stx_r  <= stx_in;
      sty_r  <= sty_in;
      dirx_r <= !in_delta_x[DELTA_BITS-1];
      diry_r <= !in_delta_y[DELTA_BITS-1];
    end
    if (state_r == S_MUL) begin
      perx_r  <= qx;
      pery_r  <= qy;
      prodx_r <= PW'(qx) * PW'(stx_r);
      prody_r <= PW'(qy) * PW'(sty_r);
    end
  end

  // Ticks go straight through; updates leave from the push state.
  assign fifo_push = (accept && (in_opcode == OP_TICK)) ||
                     ((state_r == S_PUSH) && !fifo_full);
  assign fifo_din  = (state_r == S_PUSH) ?
                     {OP_UPDATE, btn_r, perx_r, prodx_r, stx_r, dirx_r,
                      pery_r, prody_r, sty_r, diry_r} :
                     {OP_TICK, (EW-1)'(0)};

endmodule

>>> hdl/mqpg_axis.sv
// Back-end lane for one axis: batch queue, tail time and the quadrature line pair.
// Depends on mqpg_pkg.
module mqpg_axis import mqpg_pkg::*; #(
  parameter int QD   = QUEUE_DEPTH_DEF,
  parameter int SW   = DELTA_BITS_DEF - 1,
  parameter bit IS_Y = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  axis_ctl_t               ctl,
  input  logic [TIME_W-1:0]       now,
  input  logic [TIME_W-1:0]       now_inc,
  input  logic [SLOT_W-1:0]       per,
  input  logic [SLOT_W+SW-1:0]    prod,
  input  logic [SW-1:0]           steps,
  input  logic                    dir,
  output logic                    level,
  output logic                    quad,
  output logic                    drop,
  output logic [$clog2(QD+1)-1:0] used
);

  localparam int IW = $clog2(QD);
  localparam int UW = $clog2(QD + 1);

  logic [TIME_W-1:0] due_r  [QD];
  logic [SLOT_W-1:0] per_r  [QD];
  logic [SW-1:0]     cnt_r  [QD];
  logic              pos_r  [QD];

  logic [IW-1:0]     head_r, head_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic [TIME_W-1:0] tail_r, base;
  logic              level_r, quad_r, new_lvl;
  logic              full, push, fire, last;
  logic [IW:0]       wsum;
  logic [IW-1:0]     widx;

  assign full = used_r == UW'(QD);
  assign push = ctl.upd && (steps != '0) && !full;
  assign drop = ctl.upd && (steps != '0) && full;
  assign wsum = {1'b0, head_r} + (IW+1)'(used_r);
  assign widx = (wsum >= (IW+1)'(QD)) ? IW'(wsum - (IW+1)'(QD)) : wsum[IW-1:0];

  // Catch up to now; Y also moves on by half a period when it starts now.
  always_comb begin
    if (tail_r <= now) base = IS_Y ? now + TIME_W'(per >> 1) : now;
    else               base = tail_r;
  end

  assign fire    = ctl.tick && (used_r != '0) && (due_r[head_r] <= now_inc);
  assign last    = cnt_r[head_r] == SW'(1);
  assign new_lvl = ~level_r;
  assign head_nxt = (head_r == IW'(QD - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    used_nxt = used_r;
    if (push)              used_nxt = used_r + 1'b1;
    else if (fire && last) used_nxt = used_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      used_r  <= '0;
      tail_r  <= '0;
      level_r <= 1'b0;
      quad_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (push) tail_r <= base + TIME_W'(prod);
      if (fire) begin
        level_r <= new_lvl;
        quad_r  <= IS_Y ? (pos_r[head_r] ? ~new_lvl : new_lvl)
                        : (pos_r[head_r] ? new_lvl : ~new_lvl);
        if (last) head_r <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      due_r[widx] <= base + TIME_W'(per);
      per_r[widx] <= per;
      cnt_r[widx] <= steps;
      pos_r[widx] <= dir;
    end else if (fire) begin
      due_r[head_r] <= due_r[head_r] + TIME_W'(per_r[head_r]);
      cnt_r[head_r] <= cnt_r[head_r] - 1'b1;
    end
  end

  assign level = level_r;
  assign quad  = quad_r;
  assign used  = used_r;

endmodule
